FILE: src/imhpq_pkg.sv
// imhpq_pkg: shared types, constants and command/status structs for the indexed min-heap
// used by the top level, controller and datapath of the heap block; depends on nothing
package imhpq_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int KEY_SPACE  = 256;
  localparam int SW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = 8;
  localparam int VW = 32;
  localparam int CW = 9;
  localparam int KAW = $clog2(KEY_SPACE);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [1:0]        kind;
    logic [KW-1:0]     node_key;
    logic signed [VW-1:0] priority_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [KW-1:0]     out_key;
    logic signed [VW-1:0] out_value;
    logic [CW-1:0]     entry_count;
    logic              is_empty;
  } rsp_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_DECIDE, OP_INS_WR, OP_POP_RD, OP_POP_WR, OP_UPD_RD, OP_UPD_WR,
    OP_RD_CUR, OP_RD_PAR, OP_RD_KIDS, OP_SWAP, OP_RESP, OP_ROOT_WR
  } op_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic go_insert;
    logic go_pop;
    logic go_update;
    logic up_ok;
    logic down_ok;
    logic need_move;
    logic move_up;
  } sts_t;

endpackage

FILE: src/indexed_min_heap_priority_queue.sv
// indexed_min_heap_priority_queue: top level of the indexed min-heap with decrease/increase key
// one request at a time; result valid after the decide and action steps and a read and swap per
// sift level, at most 8 levels; next request taken the cycle after the result is taken
// throughput set by the sift loop over the slot memories, each with one read and one write port
// synchronous active-low reset empties the heap and sets the capacity limit to 256
// depends on imhpq_pkg, imhpq_ctrl, imhpq_dp, imhpq_ram
module indexed_min_heap_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imhpq_pkg::req_t   in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output imhpq_pkg::rsp_t   out_rsp,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata
);
  import imhpq_pkg::*;

  logic [8:0] cap_r;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 9'd256;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  imhpq_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd);
  imhpq_dp u_dp (.clk, .rst_n, .req(in_req), .cap_r, .cmd, .sts, .rsp);

  assign out_rsp = rsp;

endmodule

FILE: src/imhpq_ram.sv
// imhpq_ram: generic single write port, single read port ram with registered read
// no dependencies
module imhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/imhpq_dp.sv
// imhpq_dp: heap datapath with slot, key and position memories, present bits and count
// depends on imhpq_pkg and imhpq_ram
module imhpq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  imhpq_pkg::req_t    req,
  input  logic [8:0]         cap_r,
  input  imhpq_pkg::cmd_t    cmd,
  output imhpq_pkg::sts_t    sts,
  output imhpq_pkg::rsp_t    rsp
);
  import imhpq_pkg::*;

  localparam int SAW = $clog2(HEAP_DEPTH + 1);

  req_t              req_r;
  logic [CW-1:0]     cnt_r;
  logic [KEY_SPACE-1:0] pres_r;
  logic [SW-1:0]     cur_r, oth_r;
  logic [KW-1:0]     ck_r, ok_r;
  logic [VW-1:0]     cv_r, ov_r;
  logic [2:0]        stat_r;
  logic [KW-1:0]     pk_r;
  logic [VW-1:0]     pv_r;
  logic [1:0]        rdph_r;

  logic              sk_we, sv_we, ks_we;
  logic [SAW-1:0]    s_wa, s_ra;
  logic [KW-1:0]     sk_wd, sk_rd;
  logic [VW-1:0]     sv_wd, sv_rd;
  logic [KAW-1:0]    ks_wa, ks_ra;
  logic [SW-1:0]     ks_wd, ks_rd;

  logic              key_ok;
  logic [CW-1:0]     limit;
  logic [SW:0]       lc, rc;

  imhpq_ram #(.WIDTH(KW), .DEPTH(2 ** SAW)) u_sk (
    .clk, .we(sk_we), .waddr(s_wa), .wdata(sk_wd), .raddr(s_ra), .rdata(sk_rd));
  imhpq_ram #(.WIDTH(VW), .DEPTH(2 ** SAW)) u_sv (
    .clk, .we(sv_we), .waddr(s_wa), .wdata(sv_wd), .raddr(s_ra), .rdata(sv_rd));
  imhpq_ram #(.WIDTH(SW), .DEPTH(KEY_SPACE)) u_ks (
    .clk, .we(ks_we), .waddr(ks_wa), .wdata(ks_wd), .raddr(ks_ra), .rdata(ks_rd));

  assign key_ok = ({1'b0, req_r.node_key} < (KW+1)'(KEY_SPACE));
  assign limit = (cap_r > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : cap_r;
  assign lc = {cur_r, 1'b0};
  assign rc = {cur_r, 1'b1};

  // status toward controller
  always_comb begin
    sts = '0;
    sts.go_insert = (req_r.kind == KIND_INSERT) && key_ok && !pres_r[req_r.node_key[KAW-1:0]]
                    && (cnt_r < limit);
    sts.go_pop    = (req_r.kind == KIND_POP) && (cnt_r != '0);
    sts.go_update = (req_r.kind == KIND_UPDATE) && key_ok && pres_r[req_r.node_key[KAW-1:0]];
    sts.up_ok     = (cur_r > SW'(1)) && !($signed(cv_r) > $signed(ov_r));
    sts.down_ok   = (lc <= {1'b0, cnt_r}) && ($signed(cv_r) > $signed(ov_r));
    // old value of the updated slot arrives on sv_rd during the update write
    sts.need_move = (ks_rd >= SW'(1)) && (ks_rd <= cnt_r) && (sv_rd != req_r.priority_value);
    sts.move_up   = $signed(sv_rd) > $signed(req_r.priority_value);
  end

  always_comb begin
    sk_we = 1'b0; sv_we = 1'b0; ks_we = 1'b0;
    s_wa = '0; s_ra = '0; sk_wd = '0; sv_wd = '0;
    ks_wa = req_r.node_key[KAW-1:0]; ks_ra = req_r.node_key[KAW-1:0]; ks_wd = '0;
    case (cmd.op)
      OP_INS_WR: begin
        sk_we = 1'b1; sv_we = 1'b1; ks_we = 1'b1;
        s_wa = SAW'(cnt_r) + SAW'(1);
        sk_wd = req_r.node_key; sv_wd = req_r.priority_value;
        ks_wd = SW'(cnt_r) + SW'(1);
      end
      OP_POP_RD: s_ra = SAW'(1);
      OP_POP_WR: begin
        s_ra = SAW'(cnt_r);
      end
      OP_ROOT_WR: begin
        sk_we = 1'b1; sv_we = 1'b1; ks_we = 1'b1;
        s_wa = SAW'(1); sk_wd = ck_r; sv_wd = cv_r;
        ks_wa = ck_r[KAW-1:0]; ks_wd = SW'(1);
      end
      OP_UPD_RD: s_ra = SAW'(ks_rd);
      OP_UPD_WR: begin
        sv_we = 1'b1; s_wa = SAW'(cur_r); sv_wd = req_r.priority_value;
      end
      OP_RD_CUR: s_ra = SAW'(cur_r);
      OP_RD_PAR: s_ra = SAW'(cur_r >> 1);
      OP_RD_KIDS: s_ra = (rdph_r == 2'd0) ? SAW'(lc) : SAW'(rc);
      OP_SWAP: begin
        sk_we = 1'b1; sv_we = 1'b1; ks_we = 1'b1;
        if (rdph_r == 2'd0) begin
          s_wa = SAW'(cur_r); sk_wd = ok_r; sv_wd = ov_r;
          ks_wa = ok_r[KAW-1:0]; ks_wd = cur_r;
        end else begin
          s_wa = SAW'(oth_r); sk_wd = ck_r; sv_wd = cv_r;
          ks_wa = ck_r[KAW-1:0]; ks_wd = oth_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pres_r <= '0;
      rdph_r <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          req_r <= req; rdph_r <= '0;
          stat_r <= ST_OK; pk_r <= '0; pv_r <= '0;
        end
        OP_DECIDE: begin
          case (req_r.kind)
            KIND_INSERT: stat_r <= !key_ok ? ST_ABSENT :
                                   pres_r[req_r.node_key[KAW-1:0]] ? ST_PRESENT :
                                   (cnt_r >= limit) ? ST_FULL : ST_OK;
            KIND_POP:    stat_r <= (cnt_r == '0) ? ST_EMPTY : ST_OK;
            KIND_UPDATE: stat_r <= sts.go_update ? ST_OK : ST_ABSENT;
            default:     stat_r <= ST_OK;
          endcase
        end
        OP_INS_WR: begin
          pres_r[req_r.node_key[KAW-1:0]] <= 1'b1;
          cnt_r <= cnt_r + CW'(1);
          cur_r <= SW'(cnt_r) + SW'(1);
          ck_r <= req_r.node_key; cv_r <= req_r.priority_value;
        end
        OP_POP_RD: rdph_r <= 2'd1;
        OP_POP_WR: begin
          // phase 1: root data arrives; phase 2: last entry arrives
          if (rdph_r == 2'd1) begin
            pk_r <= sk_rd; pv_r <= sv_rd;
            pres_r[sk_rd[KAW-1:0]] <= 1'b0;
            rdph_r <= 2'd2;
          end else begin
            ck_r <= sk_rd; cv_r <= sv_rd;
            cur_r <= SW'(1);
            cnt_r <= cnt_r - CW'(1);
            rdph_r <= 2'd0;
          end
        end
        OP_UPD_RD: begin
          if (rdph_r == 2'd0) begin
            rdph_r <= 2'd1;
          end else begin
            cur_r <= ks_rd; ck_r <= req_r.node_key;
            rdph_r <= 2'd0;
          end
        end
        OP_UPD_WR: cv_r <= req_r.priority_value;
        OP_RD_CUR: rdph_r <= 2'd0;
        OP_RD_PAR: begin
          if (rdph_r == 2'd0) rdph_r <= 2'd1;
          else begin
            oth_r <= cur_r >> 1; ok_r <= sk_rd; ov_r <= sv_rd; rdph_r <= 2'd0;
          end
        end
        OP_RD_KIDS: begin
          if (rdph_r == 2'd0) rdph_r <= 2'd1;
          else if (rdph_r == 2'd1) begin
            oth_r <= SW'(lc); ok_r <= sk_rd; ov_r <= sv_rd; rdph_r <= 2'd2;
          end else begin
            rdph_r <= 2'd0;
            if (rc <= {1'b0, cnt_r} && $signed(ov_r) > $signed(sv_rd)) begin
              oth_r <= SW'(rc); ok_r <= sk_rd; ov_r <= sv_rd;
            end
          end
        end
        OP_SWAP: begin
          if (rdph_r == 2'd0) rdph_r <= 2'd1;
          else begin
            cur_r <= oth_r; rdph_r <= 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp.status = stat_r;
    rsp.out_key = pk_r;
    rsp.out_value = pv_r;
    rsp.entry_count = cnt_r;
    rsp.is_empty = (cnt_r == '0);
  end

endmodule

FILE: src/imhpq_ctrl.sv
// imhpq_ctrl: sequencing state machine for insert, pop and update with sift loops
// depends on imhpq_pkg
module imhpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  imhpq_pkg::sts_t  sts,
  output imhpq_pkg::cmd_t  cmd
);
  import imhpq_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_DEC   = 16'h0002, S_INS   = 16'h0004, S_POPR  = 16'h0008,
    S_POPA  = 16'h0010, S_POPB  = 16'h0020, S_ROOT  = 16'h0040, S_UPDR  = 16'h0080,
    S_UPDA  = 16'h0100, S_UPDW  = 16'h0200, S_PARR  = 16'h0400, S_PARA  = 16'h0800,
    S_UPCHK = 16'h1000, S_KIDS  = 16'h2000, S_SWAP  = 16'h4000, S_OUT   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   up_r, up_nxt;
  logic [1:0] ph_r, ph_nxt;

  assign in_stall = (state_r != S_IDLE) || out_valid;

  always_comb begin
    state_nxt = state_r; up_nxt = up_r; ph_nxt = ph_r;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid && !out_valid) begin
        cmd.op = OP_LATCH; state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.op = OP_DECIDE;
        if (sts.go_insert) state_nxt = S_INS;
        else if (sts.go_pop) state_nxt = S_POPR;
        else if (sts.go_update) state_nxt = S_UPDR;
        else state_nxt = S_OUT;
      end
      S_INS: begin
        cmd.op = OP_INS_WR; up_nxt = 1'b1; state_nxt = S_PARR;
      end
      S_POPR: begin cmd.op = OP_POP_RD; state_nxt = S_POPA; end
      S_POPA: begin cmd.op = OP_POP_WR; state_nxt = S_POPB; end
      S_POPB: begin cmd.op = OP_POP_WR; state_nxt = S_ROOT; end
      S_ROOT: begin
        // last entry moves into the root slot
        cmd.op = OP_ROOT_WR; up_nxt = 1'b0; state_nxt = S_KIDS; ph_nxt = 2'd0;
      end
      S_UPDR: begin cmd.op = OP_UPD_RD; state_nxt = S_UPDA; end
      S_UPDA: begin cmd.op = OP_UPD_RD; state_nxt = S_UPDW; end
      S_UPDW: begin
        cmd.op = OP_UPD_WR;
        up_nxt = sts.move_up;
        state_nxt = !sts.need_move ? S_OUT : (sts.move_up ? S_PARR : S_KIDS);
      end
      S_PARR: begin cmd.op = OP_RD_PAR; state_nxt = S_PARA; end
      S_PARA: begin cmd.op = OP_RD_PAR; state_nxt = S_UPCHK; end
      S_UPCHK: state_nxt = sts.up_ok ? S_SWAP : S_OUT;
      S_KIDS: begin
        cmd.op = OP_RD_KIDS;
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt = 2'd0; state_nxt = S_UPCHK;
          if (!up_r) state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        if (!up_r && ph_r == 2'd0 && !sts.down_ok) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op = OP_SWAP;
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            ph_nxt = 2'd0;
            state_nxt = up_r ? S_PARR : S_KIDS;
          end
        end
      end
      S_OUT: begin
        cmd.op = OP_RESP;
        if (!out_stall || !out_valid) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic ov_r;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; up_r <= 1'b0; ph_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; up_r <= up_nxt; ph_r <= ph_nxt;
      if (state_r == S_OUT) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid) else $error("result not shown");

endmodule
